>>> hdl/ucl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucl_pkg
// Shared widths, types and helpers of the UPGMA cluster engine.
// ----------------------------------------------------------------------------
package ucl_pkg;

    localparam int MAX_TAXA  = 32;
    localparam int SLOT_W    = $clog2(MAX_TAXA);
    localparam int ADDR_W    = 2 * SLOT_W;
    localparam int ID_W      = 6;
    localparam int CFG_W     = 6;
    localparam int DIST_W    = 16;
    localparam int LEAF_W    = 6;
    localparam int CNT_W     = 12;
    localparam int NUM_W     = DIST_W + LEAF_W;
    localparam int REM_W     = LEAF_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [LEAF_W-1:0] leaf_t;
    typedef logic [NUM_W-1:0]  num_t;

    // Upper-triangle address of an unordered slot pair
    function automatic addr_t pair_addr(input slot_t x, input slot_t y);
        addr_t a;
        if (x < y)
            a = {x, y};
        else
            a = {y, x};
        return a;
    endfunction

endpackage

>>> hdl/upgma_cluster_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upgma_cluster_engine_unit
// UPGMA clustering of up to 32 taxa from an upper-triangle distance load.
// ----------------------------------------------------------------------------
// Usage:
//   Write taxa_count on the cfg channel (cfg_valid/cfg_ready) while idle.
//   Stream the upper triangle row by row on the item channel, one transfer
//   per cycle; item_stall stays low during the load. The transfer with
//   last_entry high closes the load. At the wrong count one result with
//   load_error set is given; otherwise N-1 merge records follow, the root
//   carrying last_merge. item_stall is high from the closing transfer
//   until the last record has been transferred.
// Rounds: a round with m active clusters reads all m(m-1)/2 pairs in the
//   scan, then runs (m-2) updates, each with two reads through the single
//   read port of the distance memory, one multiply-add and a division in
//   the bit-serial divider.
// Reset clears the load count, taxa_count goes to 32, the memory is
//   untouched. A stalled result is held in its output register and the
//   sequencer waits; nothing is dropped.
// ----------------------------------------------------------------------------
module upgma_cluster_engine_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [ucl_pkg::CFG_W-1:0] cfg_data,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  ucl_pkg::dist_t          distance,
    input  logic                    last_entry,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [ucl_pkg::ID_W-1:0] left_cluster,
    output logic [ucl_pkg::ID_W-1:0] right_cluster,
    output logic [ucl_pkg::ID_W-1:0] new_cluster,
    output ucl_pkg::dist_t          merge_height,
    output ucl_pkg::dist_t          left_length,
    output ucl_pkg::dist_t          right_length,
    output logic                    load_error,
    output logic                    last_merge
);
    import ucl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT, ST_SCAN, ST_SCAN_END, ST_EMIT, ST_HOLD,
        ST_MRG_SEL, ST_RD_A, ST_MUL, ST_DIV, ST_WRITE, ST_FINISH
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   taxa_reg;
    logic [CNT_W-1:0]   count_reg;
    slot_t              row_reg, col_reg;
    logic [ID_W-1:0]    n_run_reg;
    logic [ID_W-1:0]    m_reg;
    slot_t              round_reg;
    slot_t              i_reg, j_reg;
    slot_t              si_reg, sj_reg;
    logic               sv_reg;
    dist_t              best_reg;
    logic               best_ok_reg;
    slot_t              a_reg, b_reg;
    slot_t              sa_reg, sb_reg;
    leaf_t              wa_reg, wb_reg;
    dist_t              h_reg;
    logic [ID_W-1:0]    p_reg;
    slot_t              ncnt_reg;
    dist_t              da_reg;
    logic               done_reg;
    slot_t              order_reg [MAX_TAXA];
    slot_t              nord_reg  [MAX_TAXA];
    logic [ID_W-1:0]    id_reg    [MAX_TAXA];
    leaf_t              leaf_reg  [MAX_TAXA];
    dist_t              ht_reg    [MAX_TAXA];

    logic               out_valid_reg;
    logic [ID_W-1:0]    left_reg, right_reg, new_reg;
    dist_t              height_reg, llen_reg, rlen_reg;
    logic               err_reg, lastm_reg;

    dist_t              mem [MAX_TAXA * MAX_TAXA];
    dist_t              rd_data_reg;

    logic [CFG_W-1:0]   n_eff;
    logic [CNT_W-1:0]   n_prod;
    logic [CNT_W-1:0]   expected;
    logic [CNT_W-1:0]   count_next;
    logic               item_acc;
    logic               mem_we;
    addr_t              waddr, raddr;
    dist_t              wdata;
    slot_t              sp;
    num_t               mul_num;
    leaf_t              wsum;
    logic               div_start, div_done;
    dist_t              div_quo;

    // Clamp the taxa count into range; expected entries N(N-1)/2
    always_comb
    begin
        if (taxa_reg < CFG_W'(2))
            n_eff = CFG_W'(2);
        else if (taxa_reg > CFG_W'(MAX_TAXA))
            n_eff = CFG_W'(MAX_TAXA);
        else
            n_eff = taxa_reg;
    end

    assign n_prod     = CNT_W'(n_eff) * (CNT_W'(n_eff) - CNT_W'(1));
    assign expected   = n_prod >> 1;
    assign count_next = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;
    assign item_acc   = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;

    assign sp      = order_reg[p_reg[SLOT_W-1:0]];
    assign wsum    = wa_reg + wb_reg;
    assign mul_num = NUM_W'(da_reg) * NUM_W'(wa_reg) + NUM_W'(rd_data_reg) * NUM_W'(wb_reg)
                   + NUM_W'(wsum >> 1);
    assign div_start = (state_reg == ST_MUL);

    ucl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_num),
        .den   (wsum),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Single write port: load entries, then merged-row averages
    always_comb
    begin
        mem_we = 1'b0;
        waddr  = {row_reg, col_reg};
        wdata  = distance;
        if (state_reg == ST_IDLE)
        begin
            mem_we = item_acc && (count_reg < expected);
        end
        else if (state_reg == ST_WRITE)
        begin
            mem_we = 1'b1;
            waddr  = pair_addr(sa_reg, sp);
            wdata  = div_quo;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_MRG_SEL: raddr = pair_addr(sa_reg, sp);
            ST_RD_A:    raddr = pair_addr(sb_reg, sp);
            default:    raddr = pair_addr(order_reg[i_reg], order_reg[j_reg]);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            taxa_reg      <= CFG_W'(MAX_TAXA);
            count_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= slot_t'(1);
            n_run_reg     <= '0;
            m_reg         <= '0;
            round_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            si_reg        <= '0;
            sj_reg        <= '0;
            sv_reg        <= 1'b0;
            best_reg      <= '0;
            best_ok_reg   <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            sa_reg        <= '0;
            sb_reg        <= '0;
            wa_reg        <= '0;
            wb_reg        <= '0;
            h_reg         <= '0;
            p_reg         <= '0;
            ncnt_reg      <= '0;
            da_reg        <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            new_reg       <= '0;
            height_reg    <= '0;
            llen_reg      <= '0;
            rlen_reg      <= '0;
            err_reg       <= 1'b0;
            lastm_reg     <= 1'b0;
            for (int k = 0; k < MAX_TAXA; k++)
            begin
                order_reg[k] <= slot_t'(k);
                nord_reg[k]  <= slot_t'(k);
                id_reg[k]    <= ID_W'(k);
                leaf_reg[k]  <= LEAF_W'(1);
                ht_reg[k]    <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                taxa_reg <= cfg_data;

            // Scan compare: strict less keeps the first pair in scan order
            sv_reg <= (state_reg == ST_SCAN);
            si_reg <= i_reg;
            sj_reg <= j_reg;
            if (sv_reg && (!best_ok_reg || rd_data_reg < best_reg))
            begin
                best_reg    <= rd_data_reg;
                best_ok_reg <= 1'b1;
                a_reg       <= si_reg;
                b_reg       <= sj_reg;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_acc)
                    begin
                        if (count_reg < expected)
                        begin
                            // advance load position through the triangle
                            if ({1'b0, col_reg} == n_eff - CFG_W'(1))
                            begin
                                row_reg <= row_reg + 1'b1;
                                col_reg <= row_reg + slot_t'(2);
                            end
                            else
                                col_reg <= col_reg + 1'b1;
                        end
                        count_reg <= count_next;
                        if (last_entry)
                        begin
                            count_reg <= '0;
                            row_reg   <= '0;
                            col_reg   <= slot_t'(1);
                            n_run_reg <= n_eff;
                            if (count_next != expected)
                            begin
                                left_reg      <= '0;
                                right_reg     <= '0;
                                new_reg       <= '0;
                                height_reg    <= '0;
                                llen_reg      <= '0;
                                rlen_reg      <= '0;
                                err_reg       <= 1'b1;
                                lastm_reg     <= 1'b0;
                                out_valid_reg <= 1'b1;
                                done_reg      <= 1'b1;
                                state_reg     <= ST_HOLD;
                            end
                            else
                                state_reg <= ST_INIT;
                        end
                    end
                end

                ST_INIT:
                begin
                    for (int k = 0; k < MAX_TAXA; k++)
                    begin
                        order_reg[k] <= slot_t'(k);
                        id_reg[k]    <= ID_W'(k);
                        leaf_reg[k]  <= LEAF_W'(1);
                        ht_reg[k]    <= '0;
                    end
                    m_reg       <= n_run_reg;
                    round_reg   <= '0;
                    i_reg       <= '0;
                    j_reg       <= slot_t'(1);
                    best_ok_reg <= 1'b0;
                    state_reg   <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    // issue one pair read per cycle, row-major over positions
                    if ({1'b0, j_reg} == m_reg - ID_W'(1))
                    begin
                        if ({1'b0, i_reg} == m_reg - ID_W'(2))
                            state_reg <= ST_SCAN_END;
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= i_reg + slot_t'(2);
                        end
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end

                ST_SCAN_END:
                begin
                    state_reg <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    sa_reg        <= order_reg[a_reg];
                    sb_reg        <= order_reg[b_reg];
                    wa_reg        <= leaf_reg[order_reg[a_reg]];
                    wb_reg        <= leaf_reg[order_reg[b_reg]];
                    h_reg         <= best_reg;
                    left_reg      <= id_reg[order_reg[a_reg]];
                    right_reg     <= id_reg[order_reg[b_reg]];
                    new_reg       <= n_run_reg + ID_W'(round_reg);
                    height_reg    <= best_reg;
                    llen_reg      <= (best_reg >= ht_reg[order_reg[a_reg]])
                                     ? best_reg - ht_reg[order_reg[a_reg]] : '0;
                    rlen_reg      <= (best_reg >= ht_reg[order_reg[b_reg]])
                                     ? best_reg - ht_reg[order_reg[b_reg]] : '0;
                    err_reg       <= 1'b0;
                    lastm_reg     <= (m_reg == ID_W'(2));
                    done_reg      <= (m_reg == ID_W'(2));
                    out_valid_reg <= 1'b1;
                    nord_reg[0]   <= order_reg[a_reg];
                    ncnt_reg      <= slot_t'(1);
                    p_reg         <= '0;
                    state_reg     <= ST_HOLD;
                end

                ST_HOLD:
                begin
                    // hold the record until the receiver takes it
                    if (!result_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= done_reg ? ST_IDLE : ST_MRG_SEL;
                    end
                end

                ST_MRG_SEL:
                begin
                    if (p_reg == m_reg)
                        state_reg <= ST_FINISH;
                    else if (p_reg[SLOT_W-1:0] == a_reg || p_reg[SLOT_W-1:0] == b_reg)
                        p_reg <= p_reg + 1'b1;
                    else
                        state_reg <= ST_RD_A;
                end

                ST_RD_A:
                begin
                    da_reg    <= rd_data_reg;
                    state_reg <= ST_MUL;
                end

                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (div_done)
                        state_reg <= ST_WRITE;
                end

                ST_WRITE:
                begin
                    nord_reg[ncnt_reg] <= sp;
                    ncnt_reg           <= ncnt_reg + 1'b1;
                    p_reg              <= p_reg + 1'b1;
                    state_reg          <= ST_MRG_SEL;
                end

                ST_FINISH:
                begin
                    for (int k = 0; k < MAX_TAXA; k++)
                        order_reg[k] <= nord_reg[k];
                    id_reg[sa_reg]   <= new_reg;
                    leaf_reg[sa_reg] <= wsum;
                    ht_reg[sa_reg]   <= h_reg;
                    m_reg            <= m_reg - 1'b1;
                    round_reg        <= round_reg + 1'b1;
                    i_reg            <= '0;
                    j_reg            <= slot_t'(1);
                    best_ok_reg      <= 1'b0;
                    state_reg        <= ST_SCAN;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid  = out_valid_reg;
    assign left_cluster  = left_reg;
    assign right_cluster = right_reg;
    assign new_cluster   = new_reg;
    assign merge_height  = height_reg;
    assign left_length   = llen_reg;
    assign right_length  = rlen_reg;
    assign load_error    = err_reg;
    assign last_merge    = lastm_reg;

endmodule

>>> hdl/ucl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ucl_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ucl_pkg::num_t        num,
    input  ucl_pkg::leaf_t       den,
    output logic                 done,
    output ucl_pkg::dist_t       quo
);
    import ucl_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    num_t                 q_reg;
    leaf_t                den_reg;
    logic [REM_W-1:0]     rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg[REM_W-2:0], q_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign done   = done_reg;
    assign quo    = q_reg[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(NUM_W);
                rem_reg  <= '0;
                q_reg    <= num;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                // shift in one numerator bit, subtract when it fits
                rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                q_reg   <= {q_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> bench/upgma_cluster_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upgma_cluster_engine_unit_tb
// Self-checking bench: loads distance matrices at several taxa counts,
// predicts every merge record and load error, and compares them in order.
// ----------------------------------------------------------------------------

typedef struct {
    logic [5:0]  left_id;
    logic [5:0]  right_id;
    logic [5:0]  new_id;
    logic [15:0] height;
    logic [15:0] left_len;
    logic [15:0] right_len;
    logic        err;
    logic        root;
} merge_rec_t;

class merge_scoreboard;
    int unsigned taxa_reg;
    int unsigned loaded;
    logic [15:0] dist_mem [32][32];
    merge_rec_t  pending_recs [$];
    int          mismatches;

    function new();
        taxa_reg   = 32;
        loaded     = 0;
        mismatches = 0;
    endfunction

    function int unsigned taxa_in_force();
        int unsigned n;
        n = taxa_reg;
        if (n < 2) n = 2;
        if (n > 32) n = 32;
        return n;
    endfunction

    function void set_taxa(logic [5:0] v);
        taxa_reg = 32'(v);
    endfunction

    // Run UPGMA over the stored triangle and queue one record per round.
    function void cluster(int unsigned n);
        longint unsigned w [32][32];
        longint unsigned nw [32][32];
        int unsigned ids [32], ids2 [32];
        longint unsigned lc [32], lc2 [32], ht [32], ht2 [32];
        int unsigned m, a, b, p, q, i, j, cnt, rnd;
        longint unsigned best, h, wa, wb;
        merge_rec_t r;
        for (i = 0; i < n; i++)
        begin
            ids[i] = i;
            lc[i]  = 1;
            ht[i]  = 0;
            w[i][i] = 0;
            for (j = i + 1; j < n; j++)
            begin
                w[i][j] = 64'(dist_mem[i][j]);
                w[j][i] = 64'(dist_mem[i][j]);
            end
        end
        rnd = 0;
        for (m = n; m > 1; m--)
        begin
            a = 0;
            b = 1;
            best = w[0][1];
            for (i = 0; i + 1 < m; i++)
                for (j = i + 1; j < m; j++)
                    if (w[i][j] < best)
                    begin
                        best = w[i][j];
                        a = i;
                        b = j;
                    end
            h = best;
            r.left_id   = 6'(ids[a]);
            r.right_id  = 6'(ids[b]);
            r.new_id    = 6'(n + rnd);
            r.height    = 16'(h);
            r.left_len  = 16'((h >= ht[a]) ? h - ht[a] : 64'd0);
            r.right_len = 16'((h >= ht[b]) ? h - ht[b] : 64'd0);
            r.err       = 1'b0;
            r.root      = (m == 2);
            pending_recs.push_back(r);
            wa = lc[a];
            wb = lc[b];
            nw[0][0] = 0;
            ids2[0] = n + rnd;
            lc2[0]  = wa + wb;
            ht2[0]  = h;
            cnt = 1;
            for (p = 0; p < m; p++)
            begin
                if (p == a || p == b) continue;
                nw[0][cnt] = (w[a][p] * wa + w[b][p] * wb + (wa + wb) / 2) / (wa + wb);
                nw[cnt][0] = nw[0][cnt];
                ids2[cnt] = ids[p];
                lc2[cnt]  = lc[p];
                ht2[cnt]  = ht[p];
                cnt++;
            end
            i = 1;
            for (p = 0; p < m; p++)
            begin
                if (p == a || p == b) continue;
                j = 1;
                for (q = 0; q < m; q++)
                begin
                    if (q == a || q == b) continue;
                    nw[i][j] = w[p][q];
                    j++;
                end
                i++;
            end
            for (p = 0; p + 1 < m; p++)
            begin
                ids[p] = ids2[p];
                lc[p]  = lc2[p];
                ht[p]  = ht2[p];
                for (q = 0; q + 1 < m; q++) w[p][q] = nw[p][q];
            end
            rnd++;
        end
    endfunction

    function void note_entry(logic [15:0] d, logic last);
        int unsigned n, full, rem, row;
        merge_rec_t r;
        n = taxa_in_force();
        full = n * (n - 1) / 2;
        if (loaded < full)
        begin
            rem = loaded;
            for (row = 0; row + 1 < n; row++)
            begin
                if (rem < n - 1 - row)
                begin
                    dist_mem[row][row + 1 + rem] = d;
                    break;
                end
                rem -= n - 1 - row;
            end
        end
        if (loaded < 4095) loaded++;
        if (last)
        begin
            if (loaded != full)
            begin
                r = '{default: '0};
                r.err = 1'b1;
                pending_recs.push_back(r);
            end
            else
                cluster(n);
            loaded = 0;
        end
    endfunction

    function void check_result(merge_rec_t got);
        merge_rec_t e;
        if (pending_recs.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected record: new=%0d err=%0b", got.new_id, got.err);
            return;
        end
        e = pending_recs.pop_front();
        if (got.left_id !== e.left_id || got.right_id !== e.right_id ||
            got.new_id !== e.new_id || got.height !== e.height ||
            got.left_len !== e.left_len || got.right_len !== e.right_len ||
            got.err !== e.err || got.root !== e.root)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch exp l=%0d r=%0d n=%0d h=%h ll=%h rl=%h e=%b t=%b",
                    e.left_id, e.right_id, e.new_id, e.height, e.left_len, e.right_len,
                    e.err, e.root);
                $display("         got l=%0d r=%0d n=%0d h=%h ll=%h rl=%h e=%b t=%b",
                    got.left_id, got.right_id, got.new_id, got.height,
                    got.left_len, got.right_len, got.err, got.root);
            end
        end
    endfunction
endclass

module upgma_cluster_engine_unit_tb;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;
    logic        item_valid;
    logic        item_stall;
    logic [15:0] distance;
    logic        last_entry;
    logic        result_valid;
    logic        result_stall;
    logic [5:0]  left_cluster;
    logic [5:0]  right_cluster;
    logic [5:0]  new_cluster;
    logic [15:0] merge_height;
    logic [15:0] left_length;
    logic [15:0] right_length;
    logic        load_error;
    logic        last_merge;

    merge_scoreboard sb;
    int          cycles = 0;
    int unsigned items_sent;
    bit          stall_burst = 1'b0;

    upgma_cluster_engine_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .distance      (distance),
        .last_entry    (last_entry),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .left_cluster  (left_cluster),
        .right_cluster (right_cluster),
        .new_cluster   (new_cluster),
        .merge_height  (merge_height),
        .left_length   (left_length),
        .right_length  (right_length),
        .load_error    (load_error),
        .last_merge    (last_merge)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog: count cycles and abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Result-side backpressure: alternate calm stretches and stall bursts
    always @(negedge clk)
    begin
        if ($urandom_range(63) == 0) stall_burst <= ~stall_burst;
        if (!rst_n)
            result_stall <= 1'b0;
        else if (stall_burst)
            result_stall <= ($urandom_range(99) < 45) ? 1'b1
                          : (($urandom_range(99) < 3) ? 1'b1 : 1'b0);
        else
            result_stall <= 1'b0;
    end

    // Check every result transfer at the rising edge
    always @(posedge clk)
    begin
        merge_rec_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.left_id   = left_cluster;
            got.right_id  = right_cluster;
            got.new_id    = new_cluster;
            got.height    = merge_height;
            got.left_len  = left_length;
            got.right_len = right_length;
            got.err       = load_error;
            got.root      = last_merge;
            sb.check_result(got);
        end
    end

    // Hold off until every expected record has been transferred, then let
    // the engine settle before touching the register.
    task automatic drain();
        while (sb.pending_recs.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_taxa(logic [5:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_taxa(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Transfer one entry; hold the payload while stalled
    task automatic send_entry(logic [15:0] d, logic last);
        int unsigned g;
        g = pick_gap();
        repeat (g) @(negedge clk);
        @(negedge clk);
        item_valid <= 1'b1;
        distance   <= d;
        last_entry <= last;
        do @(posedge clk); while (item_stall);
        sb.note_entry(d, last);
        items_sent++;
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    // Send a load of count entries; mode picks the value style
    task automatic send_load(int unsigned count, int unsigned mode);
        int unsigned k;
        logic [15:0] d;
        for (k = 0; k < count; k++)
        begin
            case (mode)
                0: d = 16'($urandom);
                1: d = 16'($urandom_range(3));
                2: d = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default: d = 16'($urandom_range(16'h0400));
            endcase
            send_entry(d, k == count - 1);
        end
    endtask

    initial
    begin
        int unsigned n, full, count, roll;
        sb          = new();
        items_sent  = 0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        item_valid  = 1'b0;
        distance    = '0;
        last_entry  = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: smallest matrix at both distance extremes
        write_taxa(6'd0);
        send_entry(16'h0000, 1'b1);
        send_entry(16'hFFFF, 1'b1);
        write_taxa(6'd1);
        send_entry(16'h8001, 1'b1);
        // Three-way tie, all distances equal
        write_taxa(6'd3);
        send_entry(16'd7, 1'b0);
        send_entry(16'd7, 1'b0);
        send_entry(16'd7, 1'b1);
        // Short load, long load, close on the first entry, then a full load of extreme values
        write_taxa(6'd4);
        send_load(2, 0);
        send_load(8, 0);
        send_load(1, 0);
        send_load(6, 2);
        // Out-of-range count acts as the maximum; close it short
        write_taxa(6'd63);
        send_load(1, 0);

        // Random loads, mostly well formed at small sizes
        while (items_sent < 170)
        begin
            if ($urandom_range(99) < 35)
                write_taxa(6'($urandom_range(9, 2)));
            n = sb.taxa_in_force();
            full = n * (n - 1) / 2;
            roll = $urandom_range(99);
            if (roll < 85)
                count = full;
            else if (roll < 93 && full > 1)
                count = $urandom_range(full - 1, 1);
            else
                count = full + $urandom_range(4, 1);
            send_load(count, $urandom_range(3));
            // Pause the sender now and then until all records are out
            if ($urandom_range(9) == 0) drain();
        end

        // One load at a large size
        write_taxa(6'd24);
        send_load(276, 3);

        while (sb.pending_recs.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_recs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
